// File: rtl/enfa_pkg.sv
// Package for the epsilon-NFA subset construction block.
// Sizes, opcodes, register indexes, sequencer states and payload structs.
// No dependencies.
package enfa_pkg;

  localparam int NFA_STATES  = 16;
  localparam int MAX_SYMBOLS = 16;
  localparam int MAX_DFA     = 128;

  localparam int NS_W      = $clog2(NFA_STATES);
  localparam int SYM_W     = $clog2(MAX_SYMBOLS);
  localparam int IDX_W     = $clog2(MAX_DFA);
  localparam int CNT_W     = $clog2(MAX_DFA + 1);
  localparam int ITER_W    = $clog2(NFA_STATES + 1);
  localparam int SITER_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int SE_DEPTH  = NFA_STATES * MAX_SYMBOLS;
  localparam int SE_AW     = $clog2(SE_DEPTH);
  localparam int TAB_DEPTH = MAX_DFA * MAX_SYMBOLS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int TAB_W     = IDX_W + 1;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_SYM_EDGE = 3'd1,
    OP_EPS_EDGE = 3'd2,
    OP_BUILD    = 3'd3,
    OP_READ     = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_STATES  = 2'd0,
    CFG_NUM_SYMBOLS = 2'd1,
    CFG_START_STATE = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_CLOSE,
    ST_LOAD,
    ST_LOAD_WT,
    ST_SYM,
    ST_MV_RD,
    ST_MV_ACC,
    ST_SR_RD,
    ST_SR_CMP,
    ST_WR_TAB,
    ST_DONE,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] from_state;
    logic [3:0] to_state;
    logic [3:0] symbol_index;
    logic [6:0] dfa_index;
  } item_t;

  typedef struct packed {
    logic [6:0]  target_index;
    logic        has_target;
    logic [15:0] subset_mask;
    logic [7:0]  dfa_count;
    logic        overflow;
  } result_t;

  // Command bundle to the symbol edge memory
  typedef struct packed {
    logic                  clr;
    logic                  we;
    logic [SE_AW-1:0]      waddr;
    logic [NFA_STATES-1:0] wdata;
    logic [SE_AW-1:0]      raddr;
  } edge_cmd_t;

endpackage

// File: rtl/enfa_edge_mem.sv
// Symbol edge memory: one NFA state mask per (state, symbol) pair.
// Per-entry valid bits give the all-zero reset and a clear of all entries at once.
// Depends on enfa_pkg.
module enfa_edge_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  enfa_pkg::edge_cmd_t            cmd,
  output logic [enfa_pkg::NFA_STATES-1:0] rdata
);

  logic [enfa_pkg::NFA_STATES-1:0] mem [enfa_pkg::SE_DEPTH];
  logic [enfa_pkg::SE_DEPTH-1:0]   valid_r;
  logic [enfa_pkg::NFA_STATES-1:0] q_r;
  logic                            qv_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      valid_r <= '0;
    end else if (cmd.we) begin
      valid_r[cmd.waddr] <= 1'b1;
    end
  end

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    q_r  <= mem[cmd.raddr];
    qv_r <= valid_r[cmd.raddr];
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

// File: rtl/enfa_close.sv
// One epsilon-closure step: adds every epsilon target in use of the states in use in set.
// Repeated by the sequencer until the set stops growing.
// Depends on enfa_pkg.
module enfa_close (
  input  logic [enfa_pkg::NFA_STATES-1:0]                            set_in,
  input  logic [enfa_pkg::NFA_STATES-1:0][enfa_pkg::NFA_STATES-1:0] eps,
  input  logic [enfa_pkg::NFA_STATES-1:0]                            lim,
  output logic [enfa_pkg::NFA_STATES-1:0]                            set_out
);

  // OR of independent rows, only from states in use
  always_comb begin
    set_out = set_in;
    for (int i = 0; i < enfa_pkg::NFA_STATES; i++) begin
      if (set_in[i] && lim[i]) begin
        set_out = set_out | (eps[i] & lim);
      end
    end
  end

endmodule

// File: rtl/enfa_subset_construction.sv
// Top level of the epsilon-NFA to DFA subset construction block.
// Uses enfa_pkg, enfa_edge_mem and enfa_close.
//
// Commands enter when start is high and busy is low. Clear and epsilon edge
// loads finish in the accept cycle; a symbol edge is a read-modify-write of
// the edge memory; a read returns its result in the cycle after accept.
// A build is run by one sequencer around a shared closure step and one
// subset-store compare: per discovered subset and symbol it reads one edge
// memory row per state in use for the move, runs closure passes until the set
// stops growing, and then searches the stored subsets one at a time for a
// non-empty set. Results appear on out_result for a single cycle with
// out_valid high and cannot be held off by the receiver.
module enfa_subset_construction (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  enfa_pkg::item_t                    in_item,
  output logic                               out_valid,
  output enfa_pkg::result_t                  out_result,
  input  logic                               cfg_we,
  input  logic [enfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [enfa_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int N  = enfa_pkg::NFA_STATES;

  enfa_pkg::state_t state_r, state_nxt;

  logic [enfa_pkg::CFG_W-1:0] num_states_r, num_symbols_r;
  logic [3:0]                 start_state_r;
  logic [N-1:0][N-1:0]        eps_r, eps_nxt;
  logic [enfa_pkg::CNT_W-1:0] count_r, count_nxt, d_r, d_nxt, k_r, k_nxt;
  logic                       ovf_r, ovf_nxt, first_r, first_nxt;
  logic [enfa_pkg::CFG_W-1:0] m_built_r, m_built_nxt;
  logic [enfa_pkg::SITER_W-1:0] s_r, s_nxt;
  logic [enfa_pkg::ITER_W-1:0]  i_r, i_nxt;
  logic [N-1:0]               cur_r, cur_nxt, acc_r, acc_nxt, set_r, set_nxt;
  logic [enfa_pkg::TAB_W-1:0] entry_r, entry_nxt;
  enfa_pkg::item_t            item_r;
  logic                       rd_hit_r, rd_hit_nxt, rd_sym_r, rd_sym_nxt;

  logic [N-1:0]               store_mem [enfa_pkg::MAX_DFA];
  logic [N-1:0]               store_q_r;
  logic [enfa_pkg::TAB_W-1:0] tab_mem [enfa_pkg::TAB_DEPTH];
  logic [enfa_pkg::TAB_W-1:0] tab_q_r;

  logic                        store_we, tab_we;
  logic [enfa_pkg::IDX_W-1:0]  store_ra, store_wa;
  logic [N-1:0]                store_wd;
  logic [enfa_pkg::TAB_AW-1:0] tab_ra, tab_wa;

  logic [enfa_pkg::CFG_W-1:0] n_eff, m_eff;
  logic [N-1:0]               lim, first_set, grown, se_rdata;
  logic                       accept, stable;
  enfa_pkg::edge_cmd_t        ecmd;

  assign busy   = (state_r != enfa_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Effective sizes and masks
  always_comb begin
    n_eff = (num_states_r > enfa_pkg::CFG_W'(N)) ? enfa_pkg::CFG_W'(N) : num_states_r;
    m_eff = (num_symbols_r > enfa_pkg::CFG_W'(enfa_pkg::MAX_SYMBOLS)) ?
            enfa_pkg::CFG_W'(enfa_pkg::MAX_SYMBOLS) : num_symbols_r;
    for (int b = 0; b < N; b++) begin
      lim[b] = (b < int'(n_eff));
    end
    first_set = '0;
    if (int'(start_state_r) < N) begin
      first_set[start_state_r] = 1'b1;
    end
  end

  enfa_close u_close (
    .set_in (set_r),
    .eps    (eps_r),
    .lim    (lim),
    .set_out(grown)
  );

  assign stable = (grown == set_r);

  enfa_edge_mem u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ecmd),
    .rdata(se_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      enfa_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_item.opcode)
            enfa_pkg::OP_SYM_EDGE: state_nxt = enfa_pkg::ST_EDGE_WR;
            enfa_pkg::OP_BUILD:    state_nxt = enfa_pkg::ST_CLOSE;
            enfa_pkg::OP_READ:     state_nxt = enfa_pkg::ST_RD_OUT;
            default:               state_nxt = enfa_pkg::ST_IDLE;
          endcase
        end
      end
      enfa_pkg::ST_EDGE_WR: state_nxt = enfa_pkg::ST_IDLE;
      enfa_pkg::ST_CLOSE: begin
        if (stable) begin
          if (first_r)           state_nxt = enfa_pkg::ST_LOAD;
          else if (set_r == '0)  state_nxt = enfa_pkg::ST_WR_TAB;
          else                   state_nxt = enfa_pkg::ST_SR_RD;
        end
      end
      enfa_pkg::ST_LOAD:
        state_nxt = (d_r >= count_r) ? enfa_pkg::ST_DONE : enfa_pkg::ST_LOAD_WT;
      enfa_pkg::ST_LOAD_WT: state_nxt = enfa_pkg::ST_SYM;
      enfa_pkg::ST_SYM:
        state_nxt = (s_r >= enfa_pkg::SITER_W'(m_eff)) ? enfa_pkg::ST_LOAD :
                    enfa_pkg::ST_MV_RD;
      enfa_pkg::ST_MV_RD:
        state_nxt = (i_r >= enfa_pkg::ITER_W'(n_eff)) ? enfa_pkg::ST_CLOSE :
                    enfa_pkg::ST_MV_ACC;
      enfa_pkg::ST_MV_ACC: state_nxt = enfa_pkg::ST_MV_RD;
      enfa_pkg::ST_SR_RD:
        state_nxt = (k_r >= count_r) ? enfa_pkg::ST_WR_TAB : enfa_pkg::ST_SR_CMP;
      enfa_pkg::ST_SR_CMP:
        state_nxt = (store_q_r == set_r) ? enfa_pkg::ST_WR_TAB : enfa_pkg::ST_SR_RD;
      enfa_pkg::ST_WR_TAB: state_nxt = enfa_pkg::ST_SYM;
      enfa_pkg::ST_DONE:   state_nxt = enfa_pkg::ST_IDLE;
      enfa_pkg::ST_RD_OUT: state_nxt = enfa_pkg::ST_IDLE;
      default:             state_nxt = enfa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    eps_nxt     = eps_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    first_nxt   = first_r;
    m_built_nxt = m_built_r;
    d_nxt       = d_r;
    k_nxt       = k_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    cur_nxt     = cur_r;
    acc_nxt     = acc_r;
    set_nxt     = set_r;
    entry_nxt   = entry_r;
    rd_hit_nxt  = rd_hit_r;
    rd_sym_nxt  = rd_sym_r;
    ecmd        = '0;
    store_we    = 1'b0;
    store_wa    = '0;
    store_wd    = set_r;
    store_ra    = '0;
    tab_we      = 1'b0;
    tab_wa      = enfa_pkg::TAB_AW'(enfa_pkg::TAB_AW'(d_r[enfa_pkg::IDX_W-1:0]) *
                  enfa_pkg::TAB_AW'(enfa_pkg::MAX_SYMBOLS) +
                  enfa_pkg::TAB_AW'(s_r[enfa_pkg::SYM_W-1:0]));
    tab_ra      = enfa_pkg::TAB_AW'(enfa_pkg::TAB_AW'(in_item.dfa_index) *
                  enfa_pkg::TAB_AW'(enfa_pkg::MAX_SYMBOLS) +
                  enfa_pkg::TAB_AW'(in_item.symbol_index));

    unique case (state_r)
      enfa_pkg::ST_IDLE: begin
        store_ra   = enfa_pkg::IDX_W'(in_item.dfa_index);
        ecmd.raddr = enfa_pkg::SE_AW'(enfa_pkg::SE_AW'(in_item.from_state) *
                     enfa_pkg::SE_AW'(enfa_pkg::MAX_SYMBOLS) +
                     enfa_pkg::SE_AW'(in_item.symbol_index));
        if (accept) begin
          unique case (in_item.opcode)
            enfa_pkg::OP_CLEAR: begin
              eps_nxt  = '0;
              ecmd.clr = 1'b1;
            end
            enfa_pkg::OP_EPS_EDGE: begin
              if (int'(in_item.from_state) < N && int'(in_item.to_state) < N) begin
                eps_nxt[in_item.from_state][in_item.to_state] = 1'b1;
              end
            end
            enfa_pkg::OP_BUILD: begin
              set_nxt     = first_set;
              first_nxt   = 1'b1;
              ovf_nxt     = 1'b0;
              m_built_nxt = m_eff;
            end
            enfa_pkg::OP_READ: begin
              rd_hit_nxt = (enfa_pkg::CNT_W'(in_item.dfa_index) < count_r);
              rd_sym_nxt = (enfa_pkg::CFG_W'(in_item.symbol_index) < m_eff) &&
                           (enfa_pkg::CFG_W'(in_item.symbol_index) < m_built_r);
            end
            default: ;
          endcase
        end
      end
      enfa_pkg::ST_EDGE_WR: begin
        // Read-modify-write of the addressed edge mask
        ecmd.waddr = enfa_pkg::SE_AW'(enfa_pkg::SE_AW'(item_r.from_state) *
                     enfa_pkg::SE_AW'(enfa_pkg::MAX_SYMBOLS) +
                     enfa_pkg::SE_AW'(item_r.symbol_index));
        ecmd.wdata = se_rdata | (N'(1) << item_r.to_state);
        ecmd.we    = (int'(item_r.from_state) < N) && (int'(item_r.to_state) < N) &&
                     (int'(item_r.symbol_index) < enfa_pkg::MAX_SYMBOLS);
      end
      enfa_pkg::ST_CLOSE: begin
        set_nxt = grown;
        if (stable) begin
          if (first_r) begin
            store_we  = 1'b1;
            store_wa  = '0;
            count_nxt = enfa_pkg::CNT_W'(1);
            d_nxt     = '0;
            first_nxt = 1'b0;
          end else if (set_r == '0) begin
            entry_nxt = '0;
          end else begin
            k_nxt = '0;
          end
        end
      end
      enfa_pkg::ST_LOAD: begin
        store_ra = d_r[enfa_pkg::IDX_W-1:0];
      end
      enfa_pkg::ST_LOAD_WT: begin
        cur_nxt = store_q_r;
        s_nxt   = '0;
      end
      enfa_pkg::ST_SYM: begin
        if (s_r >= enfa_pkg::SITER_W'(m_eff)) begin
          d_nxt = d_r + 1'b1;
        end else begin
          acc_nxt = '0;
          i_nxt   = '0;
        end
      end
      enfa_pkg::ST_MV_RD: begin
        ecmd.raddr = enfa_pkg::SE_AW'(enfa_pkg::SE_AW'(i_r[enfa_pkg::NS_W-1:0]) *
                     enfa_pkg::SE_AW'(enfa_pkg::MAX_SYMBOLS) +
                     enfa_pkg::SE_AW'(s_r[enfa_pkg::SYM_W-1:0]));
        if (i_r >= enfa_pkg::ITER_W'(n_eff)) begin
          set_nxt = acc_r;
        end
      end
      enfa_pkg::ST_MV_ACC: begin
        if (cur_r[i_r[enfa_pkg::NS_W-1:0]]) begin
          acc_nxt = acc_r | (se_rdata & lim);
        end
        i_nxt = i_r + 1'b1;
      end
      enfa_pkg::ST_SR_RD: begin
        store_ra = k_r[enfa_pkg::IDX_W-1:0];
        if (k_r >= count_r) begin
          // New subset: append, or drop it when the store is full
          if (count_r < enfa_pkg::CNT_W'(enfa_pkg::MAX_DFA)) begin
            store_we  = 1'b1;
            store_wa  = count_r[enfa_pkg::IDX_W-1:0];
            entry_nxt = {1'b1, count_r[enfa_pkg::IDX_W-1:0]};
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt   = 1'b1;
            entry_nxt = '0;
          end
        end
      end
      enfa_pkg::ST_SR_CMP: begin
        if (store_q_r == set_r) begin
          entry_nxt = {1'b1, k_r[enfa_pkg::IDX_W-1:0]};
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      enfa_pkg::ST_WR_TAB: begin
        tab_we = 1'b1;
        s_nxt  = s_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Result outputs
  always_comb begin
    out_valid  = 1'b0;
    out_result = '0;
    out_result.dfa_count = 8'(count_r);
    out_result.overflow  = ovf_r;
    unique case (state_r)
      enfa_pkg::ST_DONE: begin
        out_valid = 1'b1;
      end
      enfa_pkg::ST_RD_OUT: begin
        out_valid = 1'b1;
        out_result.has_target = rd_hit_r && rd_sym_r && tab_q_r[enfa_pkg::IDX_W];
        if (out_result.has_target) begin
          out_result.target_index = 7'(tab_q_r[enfa_pkg::IDX_W-1:0]);
        end
        if (rd_hit_r) begin
          out_result.subset_mask = 16'(store_q_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= enfa_pkg::ST_IDLE;
      num_states_r  <= enfa_pkg::CFG_W'(16);
      num_symbols_r <= enfa_pkg::CFG_W'(2);
      start_state_r <= '0;
      eps_r         <= '0;
      count_r       <= '0;
      ovf_r         <= 1'b0;
      first_r       <= 1'b0;
      m_built_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      eps_r     <= eps_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      first_r   <= first_nxt;
      m_built_r <= m_built_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          enfa_pkg::CFG_NUM_STATES:  num_states_r  <= cfg_wdata;
          enfa_pkg::CFG_NUM_SYMBOLS: num_symbols_r <= cfg_wdata;
          enfa_pkg::CFG_START_STATE: start_state_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    k_r      <= k_nxt;
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    cur_r    <= cur_nxt;
    acc_r    <= acc_nxt;
    set_r    <= set_nxt;
    entry_r  <= entry_nxt;
    rd_hit_r <= rd_hit_nxt;
    rd_sym_r <= rd_sym_nxt;
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Subset store and DFA table
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    store_q_r <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= entry_r;
    end
    tab_q_r <= tab_mem[tab_ra];
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= enfa_pkg::CNT_W'(enfa_pkg::MAX_DFA))
    else $error("subset count above store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && state_r == enfa_pkg::ST_DONE) |-> count_r == enfa_pkg::CNT_W'(enfa_pkg::MAX_DFA))
    else $error("overflow with store not full");

  a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == enfa_pkg::ST_DONE) |-> count_r != '0)
    else $error("build finished with no subsets");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == enfa_pkg::ST_SR_CMP) |-> k_r < count_r)
    else $error("search index beyond stored subsets");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

endmodule

// File: verif/enfa_subset_construction_checker.sv
// Checker for enfa_subset_construction: watches the command, result and config ports,
// predicts each result with its own subset-construction model and compares it.
// Depends on enfa_pkg.
module enfa_subset_construction_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  enfa_pkg::item_t                in_item,
  input  logic                           out_valid,
  input  enfa_pkg::result_t              out_result,
  input  logic                           cfg_we,
  input  logic [enfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [enfa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             errors,
  output int                             pending
);
  import enfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Model state
  logic [4:0]  states_cfg, symbols_cfg;
  logic [3:0]  start_cfg;
  logic [15:0] sym_tab [SE_DEPTH];
  logic [15:0] eps_tab [NFA_STATES];
  logic [15:0] subsets [MAX_DFA];
  logic [7:0]  dfa_tab [TAB_DEPTH];  // bit 7 valid, low bits target
  int          subset_cnt;
  bit          ovf;
  result_t     expected_q[$];
  result_t     want;

  function automatic logic [15:0] span_mask(int n);
    return (n >= 16) ? 16'hFFFF : 16'((32'h1 << n) - 1);
  endfunction

  function automatic int eff_states();
    return (states_cfg > NFA_STATES) ? NFA_STATES : int'(states_cfg);
  endfunction

  function automatic int eff_symbols();
    return (symbols_cfg > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(symbols_cfg);
  endfunction

  // Epsilon closure restricted to states in use
  function automatic logic [15:0] eps_close(logic [15:0] set, int n);
    logic [15:0] lim, add;
    bit grew;
    lim  = span_mask(n);
    grew = 1;
    while (grew) begin
      grew = 0;
      for (int i = 0; i < n; i++) begin
        if (set[i]) begin
          add = eps_tab[i] & lim & ~set;
          if (add != 0) begin
            set |= add;
            grew = 1;
          end
        end
      end
    end
    return set;
  endfunction

  // Full subset construction into subsets/dfa_tab
  function automatic void run_construction();
    int n, m, k;
    logic [15:0] lim, cur, nxt;
    logic [7:0] ent;
    n = eff_states();
    m = eff_symbols();
    lim = span_mask(n);
    foreach (dfa_tab[i]) dfa_tab[i] = '0;
    ovf = 0;
    subsets[0] = eps_close(16'h1 << start_cfg, n);
    subset_cnt = 1;
    for (int d = 0; d < subset_cnt; d++) begin
      cur = subsets[d];
      for (int s = 0; s < m; s++) begin
        nxt = '0;
        for (int i = 0; i < n; i++)
          if (cur[i]) nxt |= sym_tab[i*MAX_SYMBOLS + s] & lim;
        nxt = eps_close(nxt, n);
        ent = '0;
        if (nxt != 0) begin
          for (k = 0; k < subset_cnt; k++)
            if (subsets[k] == nxt) break;
          if (k < subset_cnt) begin
            ent = {1'b1, 7'(k)};
          end else if (subset_cnt < MAX_DFA) begin
            subsets[subset_cnt] = nxt;
            subset_cnt++;
            ent = {1'b1, 7'(k)};
          end else begin
            ovf = 1;
          end
        end
        dfa_tab[d*MAX_SYMBOLS + s] = ent;
      end
    end
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      states_cfg  = 5'd16;
      symbols_cfg = 5'd2;
      start_cfg   = 4'd0;
      foreach (sym_tab[i]) sym_tab[i] = '0;
      foreach (eps_tab[i]) eps_tab[i] = '0;
      subset_cnt = 0;
      ovf = 0;
      errors = 0;
      expected_q.delete();
    end else begin
      // Compare a result transaction first: a result never belongs to an item of this edge
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, out_result);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_result.target_index !== want.target_index ||
              out_result.has_target   !== want.has_target   ||
              out_result.subset_mask  !== want.subset_mask  ||
              out_result.dfa_count    !== want.dfa_count    ||
              out_result.overflow     !== want.overflow) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_result);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_STATES:  states_cfg  = cfg_wdata;
          CFG_NUM_SYMBOLS: symbols_cfg = cfg_wdata;
          CFG_START_STATE: start_cfg   = cfg_wdata[3:0];
          default: ;
        endcase
      end
      // Command transaction
      if (start && !busy) begin
        want = '0;
        case (in_item.opcode)
          OP_CLEAR: begin
            foreach (sym_tab[i]) sym_tab[i] = '0;
            foreach (eps_tab[i]) eps_tab[i] = '0;
          end
          OP_SYM_EDGE:
            sym_tab[in_item.from_state*MAX_SYMBOLS + in_item.symbol_index][in_item.to_state] = 1'b1;
          OP_EPS_EDGE: eps_tab[in_item.from_state][in_item.to_state] = 1'b1;
          OP_BUILD: begin
            run_construction();
            want.dfa_count = 8'(subset_cnt);
            want.overflow  = ovf;
            expected_q.push_back(want);
          end
          OP_READ: begin
            if (in_item.dfa_index < subset_cnt) begin
              want.subset_mask = subsets[in_item.dfa_index];
              if (in_item.symbol_index < eff_symbols() &&
                  dfa_tab[in_item.dfa_index*MAX_SYMBOLS + in_item.symbol_index][7]) begin
                want.has_target   = 1'b1;
                want.target_index =
                  dfa_tab[in_item.dfa_index*MAX_SYMBOLS + in_item.symbol_index][6:0];
              end
            end
            want.dfa_count = 8'(subset_cnt);
            want.overflow  = ovf;
            expected_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/tb_enfa_subset_construction.sv
// Top of the enfa_subset_construction testbench: clock, reset, directed and random
// command stimulus, configuration phases and the verdict.
// Depends on enfa_pkg, enfa_subset_construction and enfa_subset_construction_checker.
module tb_enfa_subset_construction;
  import enfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       start = 0;
  logic       busy;
  item_t      in_item = '0;
  logic       out_valid;
  result_t    out_result;
  logic       cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int         errors, pending;
  int         sent = 0;

  enfa_subset_construction uut (.*);
  enfa_subset_construction_checker chk (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic item_t mk(logic [2:0] op, int f, int t, int s, int d);
    item_t it;
    it.opcode       = op;
    it.from_state   = 4'(f);
    it.to_state     = 4'(t);
    it.symbol_index = 4'(s);
    it.dfa_index    = 7'(d);
    return it;
  endfunction

  // Issue one command; random gaps except in a quiet stretch
  task automatic send(item_t it);
    if (!(sent >= 250 && sent < 400) && $urandom_range(99) < 25) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drain results and let trailing edge writes finish
  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, int v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= 5'(v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic noise();
    send(mk(3'($urandom_range(1, 7)), $urandom_range(15), $urandom_range(15),
            $urandom_range(15), $urandom_range(127)));
  endtask

  initial begin
    int ns, nsym, nedge;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reads before any build, empty build, epsilon chains, unknown opcodes
    send(mk(OP_READ, 0, 0, 0, 0));
    send(mk(OP_READ, 15, 15, 15, 127));
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_EPS_EDGE, 0, 15, 0, 0));
    send(mk(OP_EPS_EDGE, 15, 3, 0, 0));
    send(mk(OP_SYM_EDGE, 3, 5, 1, 0));
    send(mk(OP_SYM_EDGE, 15, 0, 15, 0));
    send(mk(3'd5, 1, 2, 3, 4));
    send(mk(3'd6, 1, 2, 3, 4));
    send(mk(3'd7, 15, 15, 15, 127));
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 1, 1));
    send(mk(OP_READ, 0, 0, 15, 0));
    send(mk(OP_READ, 0, 0, 2, 0));
    settle();
    // Start beyond states in use, edges beyond states in use
    cfg_write(CFG_NUM_STATES, 4);
    cfg_write(CFG_NUM_SYMBOLS, 16);
    cfg_write(CFG_START_STATE, 15);
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 15, 0));
    send(mk(OP_CLEAR, 0, 0, 0, 0));
    settle();

    // Store full: "n-th symbol from the end" NFA with 2^8 subsets
    cfg_write(CFG_NUM_STATES, 9);
    cfg_write(CFG_NUM_SYMBOLS, 2);
    cfg_write(CFG_START_STATE, 0);
    send(mk(OP_SYM_EDGE, 0, 0, 0, 0));
    send(mk(OP_SYM_EDGE, 0, 0, 1, 0));
    send(mk(OP_SYM_EDGE, 0, 1, 1, 0));
    for (int i = 1; i < 8; i++) begin
      send(mk(OP_SYM_EDGE, i, i + 1, 0, 0));
      send(mk(OP_SYM_EDGE, i, i + 1, 1, 0));
    end
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 1, 127));
    send(mk(OP_READ, 0, 0, 0, 100));
    send(mk(OP_CLEAR, 0, 0, 0, 0));
    settle();

    // Random phases: configure, load a random automaton, build, read it back
    while (sent < 700) begin
      case ($urandom_range(9))
        0: ns = 16;
        1: ns = $urandom_range(6, 31);
        2: ns = 1;
        default: ns = $urandom_range(1, 5);
      endcase
      case ($urandom_range(9))
        0: nsym = 16;
        1: nsym = $urandom_range(5, 31);
        default: nsym = $urandom_range(1, 4);
      endcase
      cfg_write(CFG_NUM_STATES, ns);
      cfg_write(CFG_NUM_SYMBOLS, nsym);
      cfg_write(CFG_START_STATE, ($urandom_range(9) < 7) ? $urandom_range(0, 4)
                                                         : $urandom_range(15));
      send(mk(OP_CLEAR, 0, 0, 0, 0));
      // Keep automata with many states sparse so builds stay short
      nedge = (ns > 5) ? 4 : $urandom_range(8, 20);
      for (int e = 0; e < nedge; e++) begin
        if ($urandom_range(9) == 0) noise();
        else send(mk(($urandom_range(2) == 0) ? OP_EPS_EDGE : OP_SYM_EDGE,
                     $urandom_range(0, 5), $urandom_range(0, 5),
                     $urandom_range(0, (nsym > 4) ? 15 : 4), 0));
      end
      settle();
      send(mk(OP_BUILD, 0, 0, 0, 0));
      repeat ($urandom_range(6, 14)) begin
        send(mk(OP_READ, $urandom_range(15), $urandom_range(15),
                $urandom_range(0, (nsym > 4) ? 15 : 4),
                ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(0, 8)));
      end
      settle();
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
